// ===== rtl/bdv_pkg.sv =====
package bdv_pkg;

    localparam int MAX_DEPTH_DEF   = 12;
    localparam int OFFSET_BITS_DEF = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bdv_in_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] fail_offset;
        logic [3:0]  nest_level;
    } bdv_out_t;

    typedef enum logic [3:0] {
        PH_ROOT_LEN = 4'd0,
        PH_TYPE     = 4'd1,
        PH_KEY      = 4'd2,
        PH_SKIP     = 4'd3,
        PH_BOOL     = 4'd4,
        PH_STR_LEN  = 4'd5,
        PH_STR_DATA = 4'd6,
        PH_BIN_LEN  = 4'd7,
        PH_BIN_SUB  = 4'd8,
        PH_RX1      = 4'd9,
        PH_RX2      = 4'd10,
        PH_DOC_LEN  = 4'd11,
        PH_CWS_LEN  = 4'd12,
        PH_DONE     = 4'd13
    } phase_t;

    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_OK      = 2'd1;
    localparam logic [1:0] VERDICT_BAD     = 2'd2;

    localparam logic [7:0] T_DOUBLE = 8'h01;
    localparam logic [7:0] T_STRING = 8'h02;
    localparam logic [7:0] T_DOC    = 8'h03;
    localparam logic [7:0] T_ARRAY  = 8'h04;
    localparam logic [7:0] T_BIN    = 8'h05;
    localparam logic [7:0] T_UNDEF  = 8'h06;
    localparam logic [7:0] T_OID    = 8'h07;
    localparam logic [7:0] T_BOOL   = 8'h08;
    localparam logic [7:0] T_DATE   = 8'h09;
    localparam logic [7:0] T_NULL   = 8'h0A;
    localparam logic [7:0] T_REGEX  = 8'h0B;
    localparam logic [7:0] T_DBPTR  = 8'h0C;
    localparam logic [7:0] T_CODE   = 8'h0D;
    localparam logic [7:0] T_SYM    = 8'h0E;
    localparam logic [7:0] T_CWS    = 8'h0F;
    localparam logic [7:0] T_INT32  = 8'h10;
    localparam logic [7:0] T_TS     = 8'h11;
    localparam logic [7:0] T_INT64  = 8'h12;
    localparam logic [7:0] T_DEC128 = 8'h13;
    localparam logic [7:0] T_MAXKEY = 8'h7F;
    localparam logic [7:0] T_MINKEY = 8'hFF;

    // stack entry: end offset, array flag, array index
    typedef struct packed {
        logic [31:0] lend;
        logic        is_array;
        logic [31:0] aidx;
    } level_t;

    typedef struct packed {
        logic         we;
        logic [4:0]   waddr;
        level_t       wdata;
        logic [4:0]   raddr;
    } stk_req_t;

endpackage

// ===== rtl/bson_document_validator.sv =====
// The verdict for each accepted byte is registered into the output register.
// Throughput: one byte per cycle while the output is not stalled; the level stack sits in a
// memory whose read on a document close is hidden by a top-of-stack register.
// Reset: rst_n asynchronous, active low; clears control state, no output pending.
module bson_document_validator #(
    parameter int MAX_DEPTH   = bdv_pkg::MAX_DEPTH_DEF,
    parameter int OFFSET_BITS = bdv_pkg::OFFSET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bdv_pkg::bdv_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output bdv_pkg::bdv_out_t out_data
);
    import bdv_pkg::*;

    logic     step;
    bdv_out_t res;
    stk_req_t sreq;
    level_t   srd;

    assign in_stall = out_valid && out_stall;
    assign step = in_valid && !in_stall;

    bdv_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk   (clk),
        .req   (sreq),
        .rdata (srd)
    );

    bdv_core #(.MAX_DEPTH(MAX_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .din   (in_data),
        .dout  (res),
        .sreq  (sreq),
        .srd   (srd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data <= res;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.verdict != 2'd3)
        else $error("bad verdict code");
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.verdict != VERDICT_BAD |-> out_data.fail_offset == 32'd0)
        else $error("offset without failure");

endmodule

// ===== rtl/bdv_stack.sv =====
module bdv_stack #(
    parameter int MAX_DEPTH = bdv_pkg::MAX_DEPTH_DEF
) (
    input  logic              clk,
    input  bdv_pkg::stk_req_t req,
    output bdv_pkg::level_t   rdata
);
    import bdv_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    level_t mem [MAX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rdata <= mem[req.raddr[AW-1:0]];
    end

endmodule

// ===== rtl/bdv_core.sv =====
module bdv_core #(
    parameter int MAX_DEPTH   = bdv_pkg::MAX_DEPTH_DEF,
    parameter int OFFSET_BITS = bdv_pkg::OFFSET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bdv_pkg::bdv_in_t  din,
    output bdv_pkg::bdv_out_t dout,
    output bdv_pkg::stk_req_t sreq,
    input  bdv_pkg::level_t   srd
);
    import bdv_pkg::*;

    localparam logic [32:0] OFF_MAX = 33'((64'd1 << OFFSET_BITS) - 64'd1);

    // top-of-stack cache; memory holds entries below it
    level_t      top_reg, top_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    phase_t      ph_reg, ph_next;
    logic [7:0]  ty_reg, ty_next;
    logic [31:0] gath_reg, gath_next;
    logic [31:0] left_reg, left_next;
    logic [33:0] key_reg, key_next;
    logic [31:0] scope_reg, scope_next;
    logic        fail_reg, fail_next;
    logic [31:0] pos_reg, pos_next;

    level_t      top;
    logic [32:0] p, lim, len, endv;
    logic [31:0] g;
    logic        f;
    logic [35:0] kv;
    logic [1:0]  sh;
    logic [1:0]  verd;

    always_comb
    begin
        top = pend_reg ? srd : top_reg;
        top_next = top;
        cnt_next = cnt_reg;
        pend_next = 1'b0;
        ph_next = ph_reg;
        ty_next = ty_reg;
        gath_next = gath_reg;
        left_next = left_reg;
        key_next = key_reg;
        scope_next = scope_reg;
        fail_next = fail_reg;
        pos_next = pos_reg;
        sreq = '0;
        p = {1'b0, pos_reg};
        lim = {1'b0, top.lend} - 33'd1;
        len = '0;
        endv = '0;
        g = gath_reg;
        f = 1'b0;
        kv = '0;
        sh = '0;
        verd = VERDICT_PENDING;
        if (step)
        begin
            if (!fail_reg)
            begin
                if (ph_reg != PH_ROOT_LEN && ph_reg != PH_DONE && cnt_reg == 6'd0)
                begin
                    f = 1'b1;
                end
                else
                begin
                    case (ph_reg)
                        PH_ROOT_LEN, PH_DOC_LEN, PH_CWS_LEN, PH_STR_LEN, PH_BIN_LEN:
                        begin
                            if (left_reg == 32'd0 || left_reg > 32'd4)
                            begin
                                f = 1'b1;
                            end
                            else
                            begin
                                sh = 2'(3'd4 - left_reg[2:0]);
                                g = gath_reg | (32'(din.data_byte) << {sh, 3'b000});
                                gath_next = g;
                                left_next = left_reg - 32'd1;
                                if (left_reg == 32'd1)
                                begin
                                    len = {1'b0, g};
                                    if (g[31])
                                    begin
                                        f = 1'b1;
                                    end
                                    else
                                    begin
                                        case (ph_reg)
                                            PH_ROOT_LEN:
                                            begin
                                                if (len < 33'd5 || len - 33'd1 > OFF_MAX)
                                                begin
                                                    f = 1'b1;
                                                end
                                                else if (cnt_reg >= 6'(MAX_DEPTH))
                                                begin
                                                    f = 1'b1;
                                                end
                                                else
                                                begin
                                                    top_next = '{lend: g, is_array: 1'b0,
                                                                 aidx: 32'd0};
                                                    cnt_next = cnt_reg + 6'd1;
                                                    ph_next = PH_TYPE;
                                                end
                                            end
                                            PH_DOC_LEN:
                                            begin
                                                endv = p - 33'd3 + len;
                                                if (len < 33'd5)
                                                begin
                                                    f = 1'b1;
                                                end
                                                else if (ty_reg == T_CWS ?
                                                         endv != {1'b0, scope_reg} :
                                                         endv > lim)
                                                begin
                                                    f = 1'b1;
                                                end
                                                else if (cnt_reg >= 6'(MAX_DEPTH))
                                                begin
                                                    f = 1'b1;
                                                end
                                                else
                                                begin
                                                    sreq.we = 1'b1;
                                                    sreq.waddr = 5'(cnt_reg - 6'd1);
                                                    sreq.wdata = top;
                                                    top_next = '{lend: endv[31:0],
                                                        is_array: (ty_reg == T_ARRAY),
                                                        aidx: 32'd0};
                                                    cnt_next = cnt_reg + 6'd1;
                                                    ph_next = PH_TYPE;
                                                end
                                            end
                                            PH_CWS_LEN:
                                            begin
                                                endv = p - 33'd3 + len;
                                                if (len < 33'd14 || endv > lim)
                                                begin
                                                    f = 1'b1;
                                                end
                                                else
                                                begin
                                                    scope_next = endv[31:0];
                                                    ph_next = PH_STR_LEN;
                                                    gath_next = '0;
                                                    left_next = 32'd4;
                                                end
                                            end
                                            PH_STR_LEN:
                                            begin
                                                endv = p + 33'd1 + len;
                                                if (len < 33'd1)
                                                begin
                                                    f = 1'b1;
                                                end
                                                else if (ty_reg == T_CWS)
                                                begin
                                                    f = endv > {1'b0, scope_reg};
                                                end
                                                else if (ty_reg == T_DBPTR)
                                                begin
                                                    f = {1'b0, endv} + 34'd12 > {1'b0, lim};
                                                end
                                                else
                                                begin
                                                    f = endv > lim;
                                                end
                                                if (!f)
                                                begin
                                                    left_next = g;
                                                    ph_next = PH_STR_DATA;
                                                end
                                            end
                                            default:
                                            begin
                                                if ({1'b0, p + 33'd2} + {1'b0, len} >
                                                    {1'b0, lim})
                                                begin
                                                    f = 1'b1;
                                                end
                                                else
                                                begin
                                                    ph_next = PH_BIN_SUB;
                                                end
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                        PH_TYPE:
                        begin
                            if (p >= lim)
                            begin
                                if (p != lim || din.data_byte != 8'd0)
                                begin
                                    f = 1'b1;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg - 6'd1;
                                    if (cnt_reg == 6'd1)
                                    begin
                                        ph_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        sreq.raddr = 5'(cnt_reg - 6'd2);
                                        pend_next = 1'b1;
                                    end
                                end
                            end
                            else if (!((din.data_byte >= T_DOUBLE && din.data_byte <= T_DEC128)
                                       || din.data_byte == T_MAXKEY
                                       || din.data_byte == T_MINKEY))
                            begin
                                f = 1'b1;
                            end
                            else
                            begin
                                ty_next = din.data_byte;
                                key_next = '0;
                                ph_next = PH_KEY;
                            end
                        end
                        PH_KEY:
                        begin
                            if (p >= lim)
                            begin
                                f = 1'b1;
                            end
                            else if (din.data_byte != 8'd0)
                            begin
                                if (top.is_array)
                                begin
                                    if (din.data_byte < 8'h30 || din.data_byte > 8'h39 ||
                                        (key_reg[33] && key_reg[31:0] == 32'd0))
                                    begin
                                        key_next[32] = 1'b1;
                                    end
                                    else
                                    begin
                                        kv = {4'd0, key_reg[31:0]} * 36'd10 +
                                             36'(din.data_byte - 8'h30);
                                        key_next = {1'b1, key_reg[32] | (kv[35:32] != 4'd0),
                                                    kv[31:0]};
                                    end
                                end
                            end
                            else
                            begin
                                if (top.is_array &&
                                    (key_reg[32] || !key_reg[33] || key_reg[31:0] != top.aidx))
                                begin
                                    f = 1'b1;
                                end
                                else
                                begin
                                    if (top.is_array)
                                    begin
                                        top_next.aidx = top.aidx + 32'd1;
                                    end
                                    len = 33'd0;
                                    ph_next = PH_TYPE;
                                    case (ty_reg)
                                        T_DOUBLE, T_DATE, T_TS, T_INT64:
                                        begin
                                            len = 33'd8; ph_next = PH_SKIP;
                                        end
                                        T_OID:
                                        begin
                                            len = 33'd12; ph_next = PH_SKIP;
                                        end
                                        T_INT32:
                                        begin
                                            len = 33'd4; ph_next = PH_SKIP;
                                        end
                                        T_DEC128:
                                        begin
                                            len = 33'd16; ph_next = PH_SKIP;
                                        end
                                        T_BOOL:
                                        begin
                                            len = 33'd1; ph_next = PH_BOOL;
                                        end
                                        T_STRING, T_CODE, T_SYM:
                                        begin
                                            len = 33'd5; ph_next = PH_STR_LEN;
                                        end
                                        T_DBPTR:
                                        begin
                                            len = 33'd17; ph_next = PH_STR_LEN;
                                        end
                                        T_DOC, T_ARRAY:
                                        begin
                                            len = 33'd5; ph_next = PH_DOC_LEN;
                                        end
                                        T_BIN:
                                        begin
                                            len = 33'd5; ph_next = PH_BIN_LEN;
                                        end
                                        T_REGEX:
                                        begin
                                            len = 33'd2; ph_next = PH_RX1;
                                        end
                                        T_CWS:
                                        begin
                                            len = 33'd14; ph_next = PH_CWS_LEN;
                                        end
                                        default:
                                        begin
                                            len = 33'd0; ph_next = PH_TYPE;
                                        end
                                    endcase
                                    if ({1'b0, p + 33'd1} + {1'b0, len} > {1'b0, lim})
                                    begin
                                        f = 1'b1;
                                    end
                                    left_next = (ph_next == PH_SKIP) ? len[31:0] : 32'd4;
                                    gath_next = '0;
                                end
                            end
                        end
                        PH_SKIP:
                        begin
                            if (left_reg <= 32'd1)
                            begin
                                left_next = '0;
                                ph_next = PH_TYPE;
                            end
                            else
                            begin
                                left_next = left_reg - 32'd1;
                            end
                        end
                        PH_BOOL:
                        begin
                            if (din.data_byte > 8'd1)
                            begin
                                f = 1'b1;
                            end
                            else
                            begin
                                ph_next = PH_TYPE;
                            end
                        end
                        PH_STR_DATA:
                        begin
                            if (left_reg != 32'd0)
                            begin
                                left_next = left_reg - 32'd1;
                            end
                            if (left_reg <= 32'd1)
                            begin
                                if (din.data_byte != 8'd0)
                                begin
                                    f = 1'b1;
                                end
                                else if (ty_reg == T_DBPTR)
                                begin
                                    ph_next = PH_SKIP; left_next = 32'd12;
                                end
                                else if (ty_reg == T_CWS)
                                begin
                                    ph_next = PH_DOC_LEN; left_next = 32'd4;
                                    gath_next = '0;
                                end
                                else
                                begin
                                    ph_next = PH_TYPE;
                                end
                            end
                        end
                        PH_BIN_SUB:
                        begin
                            if (gath_reg == 32'd0)
                            begin
                                ph_next = PH_TYPE;
                            end
                            else
                            begin
                                ph_next = PH_SKIP; left_next = gath_reg;
                            end
                        end
                        PH_RX1, PH_RX2:
                        begin
                            if (p >= lim)
                            begin
                                f = 1'b1;
                            end
                            else if (din.data_byte == 8'd0)
                            begin
                                ph_next = (ph_reg == PH_RX1) ? PH_RX2 : PH_TYPE;
                            end
                        end
                        default:
                        begin
                            f = 1'b1;
                        end
                    endcase
                end
                if (f)
                begin
                    // failed step: keep stack state of the prior cycle
                    sreq.we = 1'b0;
                    pend_next = pend_reg;
                    top_next = top_reg;
                    cnt_next = cnt_reg;
                end
                if (!f && din.last_byte && ph_next != PH_DONE)
                begin
                    f = 1'b1;
                end
                fail_next = f;
                if (!f)
                begin
                    if (p + 33'd1 <= OFF_MAX)
                    begin
                        pos_next = pos_reg + 32'd1;
                    end
                    if (din.last_byte)
                    begin
                        verd = VERDICT_OK;
                    end
                end
                else
                begin
                    verd = VERDICT_BAD;
                end
            end
            else
            begin
                verd = VERDICT_BAD;
                pend_next = pend_reg;
            end
            dout.verdict = verd;
            dout.fail_offset = fail_next ? pos_next : 32'd0;
            dout.nest_level = cnt_next[3:0];
            if (din.last_byte)
            begin
                pos_next = '0;
                cnt_next = '0;
                ph_next = PH_ROOT_LEN;
                ty_next = '0;
                gath_next = '0;
                left_next = 32'd4;
                key_next = '0;
                scope_next = '0;
                fail_next = 1'b0;
                pend_next = 1'b0;
            end
        end
        else
        begin
            dout = '0;
        end
        if (pend_reg && !pend_next)
        begin
            top_next = step ? top_next : srd;
        end
        if (pend_next && pend_reg)
        begin
            top_next = top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            ph_reg <= PH_ROOT_LEN;
            ty_reg <= '0;
            gath_reg <= '0;
            left_reg <= 32'd4;
            key_reg <= '0;
            scope_reg <= '0;
            fail_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pend_reg <= pend_next;
            ph_reg <= ph_next;
            ty_reg <= ty_next;
            gath_reg <= gath_next;
            left_reg <= left_next;
            key_reg <= key_next;
            scope_reg <= scope_next;
            fail_reg <= fail_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

endmodule
